// File: src/lpde_pkg.sv
package lpde_pkg;

   localparam int BITS_PER_PIXEL     = 24;
   localparam int RESET_SLOTS_DEF    = 50;
   localparam int QUEUE_DEPTH        = 2;
   localparam int SCALE_W            = 17;
   localparam logic [5:0] MAX_LEVEL  = 6'd45;
   localparam logic [SCALE_W-1:0] SCALE_UNITY = 17'd65536;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   localparam logic [7:0] REG_BRIGHT_EN    = 8'd0;
   localparam logic [7:0] REG_BRIGHT_LEVEL = 8'd1;
   localparam logic [7:0] REG_DUTY_ONE     = 8'd2;
   localparam logic [7:0] REG_DUTY_ZERO    = 8'd3;

   typedef struct packed {
      logic               bright_en;
      logic [SCALE_W-1:0] scale;
      logic [7:0]         duty_one;
      logic [7:0]         duty_zero;
   } cfg_type;

   typedef struct packed {
      logic                      opcode;
      logic [BITS_PER_PIXEL-1:0] word;
   } entry_type;

   // round(tan(d deg) * 2^16), unsigned Q1.16
   function automatic logic [SCALE_W-1:0] tan_q16(input logic [5:0] level);
      logic [SCALE_W-1:0] v;
      unique case (level)
         6'd0:  v = 17'd0;
         6'd1:  v = 17'd1144;
         6'd2:  v = 17'd2289;
         6'd3:  v = 17'd3435;
         6'd4:  v = 17'd4583;
         6'd5:  v = 17'd5734;
         6'd6:  v = 17'd6888;
         6'd7:  v = 17'd8047;
         6'd8:  v = 17'd9210;
         6'd9:  v = 17'd10380;
         6'd10: v = 17'd11556;
         6'd11: v = 17'd12739;
         6'd12: v = 17'd13930;
         6'd13: v = 17'd15130;
         6'd14: v = 17'd16340;
         6'd15: v = 17'd17560;
         6'd16: v = 17'd18792;
         6'd17: v = 17'd20036;
         6'd18: v = 17'd21294;
         6'd19: v = 17'd22566;
         6'd20: v = 17'd23853;
         6'd21: v = 17'd25157;
         6'd22: v = 17'd26478;
         6'd23: v = 17'd27818;
         6'd24: v = 17'd29179;
         6'd25: v = 17'd30560;
         6'd26: v = 17'd31964;
         6'd27: v = 17'd33392;
         6'd28: v = 17'd34846;
         6'd29: v = 17'd36327;
         6'd30: v = 17'd37837;
         6'd31: v = 17'd39378;
         6'd32: v = 17'd40951;
         6'd33: v = 17'd42560;
         6'd34: v = 17'd44205;
         6'd35: v = 17'd45889;
         6'd36: v = 17'd47615;
         6'd37: v = 17'd49385;
         6'd38: v = 17'd51202;
         6'd39: v = 17'd53070;
         6'd40: v = 17'd54991;
         6'd41: v = 17'd56970;
         6'd42: v = 17'd59009;
         6'd43: v = 17'd61113;
         6'd44: v = 17'd63287;
         default: v = SCALE_UNITY;
      endcase
      return v;
   endfunction

endpackage

// File: src/lpde_front.sv
module lpde_front
   import lpde_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_opcode,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_entry
);

   logic       stage_valid_ff, stage_valid_in;
   logic       stage_op_ff;
   logic [7:0] stage_r_ff, stage_g_ff, stage_b_ff;
   logic [SCALE_W-1:0] scale;

   assign req_ready  = !stage_valid_ff || push_ready;
   assign push_valid = stage_valid_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_op_ff <= req_opcode;
         stage_r_ff  <= req_red;
         stage_g_ff  <= req_green;
         stage_b_ff  <= req_blue;
      end
   end

   // unity scale passes the LSB-cleared byte through unchanged
   assign scale = cfg.bright_en ? cfg.scale : SCALE_UNITY;

   function automatic logic [7:0] scale_byte(input logic [7:0] raw,
                                             input logic [SCALE_W-1:0] s);
      logic [SCALE_W+7:0] prod;
      prod = {{SCALE_W{1'b0}}, raw[7:1], 1'b0} * {8'd0, s};
      return prod[23:16];
   endfunction

   assign push_entry.opcode = stage_op_ff;
   assign push_entry.word   = {scale_byte(stage_b_ff, scale),
                               scale_byte(stage_r_ff, scale),
                               scale_byte(stage_g_ff, scale)};

endmodule

// File: src/lpde_queue.sv
module lpde_queue
   import lpde_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/lpde_back.sv
module lpde_back
   import lpde_pkg::*;
#(
   parameter int RESET_SLOTS = RESET_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_entry,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_duty,
   output logic       rsp_last
);

   localparam int MAX_SLOTS = (RESET_SLOTS > BITS_PER_PIXEL) ? RESET_SLOTS : BITS_PER_PIXEL;
   localparam int CNT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic                      busy_ff, busy_in;
   logic                      op_ff;
   logic [BITS_PER_PIXEL-1:0] word_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                duty_ff;
   logic                      last_ff;
   logic                      advance, final_slot, take;

   assign advance    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign final_slot = (op_ff == OP_FRAME) ? (cnt_ff == CNT_W'(RESET_SLOTS - 1))
                                           : (cnt_ff == CNT_W'(BITS_PER_PIXEL - 1));
   assign pop_ready  = !busy_ff || (advance && final_slot);
   assign take       = pop_valid && pop_ready;

   always_comb begin
      busy_in = busy_ff;
      if (take) begin
         busy_in = 1'b1;
      end else if (advance && final_slot) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff   <= pop_entry.opcode;
         word_ff <= pop_entry.word;
         cnt_ff  <= '0;
      end else if (advance) begin
         word_ff <= {word_ff[BITS_PER_PIXEL-2:0], 1'b0};
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (advance) begin
         if (op_ff == OP_FRAME) begin
            duty_ff <= 8'd0;
         end else begin
            duty_ff <= word_ff[BITS_PER_PIXEL-1] ? cfg.duty_one : cfg.duty_zero;
         end
         last_ff <= final_slot;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty  = duty_ff;
   assign rsp_last  = last_ff;

endmodule

// File: src/led_pixel_duty_encoder.sv
// Path: the first duty value of an item passes the front stage, the queue, the
// serialiser shift register and the slot register when the back end is free.
// Throughput: 24 bit slots per pixel item, RESET_SLOTS slots per end-frame item,
// set by the serialiser emitting one bit slot per cycle while the receiver is ready.
// Reset (synchronous): empties the pipeline and queue, configuration registers take their defaults.
module led_pixel_duty_encoder
   import lpde_pkg::*;
#(
   parameter int RESET_SLOTS = RESET_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_duty,
   output logic       rsp_last
);

   cfg_type   cfg_ff;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;
   logic [5:0] level;

   assign csr_ready = 1'b1;
   // level saturates at the write; the table entry is kept, not the angle
   assign level = (csr_data[5:0] > MAX_LEVEL) ? MAX_LEVEL : csr_data[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_en <= 1'b1;
         cfg_ff.scale     <= SCALE_UNITY;
         cfg_ff.duty_one  <= 8'd60;
         cfg_ff.duty_zero <= 8'd30;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BRIGHT_EN:    cfg_ff.bright_en <= csr_data[0];
            REG_BRIGHT_LEVEL: cfg_ff.scale     <= tan_q16(level);
            REG_DUTY_ONE:     cfg_ff.duty_one  <= csr_data;
            REG_DUTY_ZERO:    cfg_ff.duty_zero <= csr_data;
            default: ;
         endcase
      end
   end

   lpde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lpde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lpde_back #(
      .RESET_SLOTS (RESET_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_duty  (rsp_duty),
      .rsp_last  (rsp_last)
   );

endmodule

// File: tb/tb_top.sv
module tb_top;
   import lpde_pkg::*;

   localparam int FRAME_SLOTS    = 50;
   localparam int PIXEL_SLOTS    = 24;
   localparam int LEVEL_CAP      = 45;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 30;

   typedef struct packed {
      logic [7:0] duty;
      logic       last;
   } duty_slot_type;

   typedef struct packed {
      bit          is_reg;
      logic [7:0]  idx;
      logic [7:0]  data;
      logic        op;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      bit          typed;
      logic [23:0] word;
   } step_row_type;

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_index;
   logic [7:0] csr_data;
   logic       req_valid;
   logic       req_ready;
   logic       req_opcode;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_duty;
   logic       rsp_last;

   // round(tan(d deg) * 2^16)
   int unsigned tan_deg_q16 [46] = '{
      0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
      11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
      23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
      37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
      54991, 56970, 59009, 61113, 63287, 65536
   };

   logic       cfg_en;
   logic [5:0] cfg_level;
   logic [7:0] cfg_one;
   logic [7:0] cfg_zero;

   duty_slot_type pending_slots [$];
   step_row_type  plan [$];
   bit            item_typed;
   logic [23:0]   item_word;
   bit            no_idle;
   int            error_count;
   int            cycle_count;

   led_pixel_duty_encoder #(.RESET_SLOTS(FRAME_SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_duty   (rsp_duty),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("led_pixel_duty_encoder: mismatch");
      $finish;
   end

   function automatic logic [7:0] scale_byte(input logic [7:0] raw);
      logic [7:0]  even;
      logic [31:0] prod;
      even = raw & 8'hFE;
      if (!cfg_en)
         return even;
      prod = even * tan_deg_q16[cfg_level];
      return prod[23:16];
   endfunction

   // bit order on the wire: blue, red, green
   function automatic logic [23:0] pixel_word(input logic [7:0] red, green, blue);
      return {scale_byte(blue), scale_byte(red), scale_byte(green)};
   endfunction

   task automatic apply_reg_write(input logic [7:0] idx, input logic [7:0] data);
      case (idx)
         REG_BRIGHT_EN: begin
            cfg_en = data[0];
         end
         REG_BRIGHT_LEVEL: begin
            cfg_level = (data[5:0] > LEVEL_CAP) ? 6'(LEVEL_CAP) : data[5:0];
         end
         REG_DUTY_ONE: begin
            cfg_one = data;
         end
         REG_DUTY_ZERO: begin
            cfg_zero = data;
         end
         default: begin
         end
      endcase
   endtask

   task automatic queue_slots(input logic op, input logic [23:0] word);
      duty_slot_type s;
      if (op == OP_FRAME) begin
         for (int k = 0; k < FRAME_SLOTS; k++) begin
            s.duty = 8'd0;
            s.last = (k == FRAME_SLOTS - 1);
            pending_slots.push_back(s);
         end
      end else begin
         for (int k = 0; k < PIXEL_SLOTS; k++) begin
            s.duty = word[PIXEL_SLOTS - 1 - k] ? cfg_one : cfg_zero;
            s.last = (k == PIXEL_SLOTS - 1);
            pending_slots.push_back(s);
         end
      end
   endtask

   task automatic note_mismatch(input logic [7:0] want_duty, input logic want_last);
      error_count++;
      if (error_count <= 10)
         $display("duty slot wrong: expected duty %0d last %0d, got duty %0d last %0d",
                  want_duty, want_last, rsp_duty, rsp_last);
   endtask

   always @(posedge clock) begin : slot_checker
      duty_slot_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            apply_reg_write(csr_index, csr_data);
         if (req_valid && req_ready)
            queue_slots(req_opcode,
                        item_typed ? item_word : pixel_word(req_red, req_green, req_blue));
         if (rsp_valid && rsp_ready) begin
            if (pending_slots.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unrequested duty slot: duty %0d last %0d", rsp_duty, rsp_last);
            end else begin
               want = pending_slots.pop_front();
               if (rsp_duty !== want.duty || rsp_last !== want.last)
                  note_mismatch(want.duty, want.last);
            end
         end
      end
   end

   // receiver: stalls in short bursts unless idling is switched off
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_ready = 1;
      end
   end

   task automatic push_item(input logic op, input logic [7:0] red, green, blue,
                            input bit typed, input logic [23:0] word);
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid  = 1;
      req_opcode = op;
      req_red    = red;
      req_green  = green;
      req_blue   = blue;
      item_typed = typed;
      item_word  = word;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 0;
      while (pending_slots.size() != 0) @(negedge clock);
   endtask

   function automatic step_row_type reg_row(input logic [7:0] idx, input logic [7:0] data);
      step_row_type row;
      row        = '0;
      row.is_reg = 1;
      row.idx    = idx;
      row.data   = data;
      return row;
   endfunction

   function automatic step_row_type pix_row(input logic op, input logic [7:0] red, green, blue,
                                            input bit typed, input logic [23:0] word);
      step_row_type row;
      row       = '0;
      row.op    = op;
      row.red   = red;
      row.green = green;
      row.blue  = blue;
      row.typed = typed;
      row.word  = word;
      return row;
   endfunction

   task automatic shuffle_settings();
      logic [7:0] v;
      if ($urandom_range(0, 1))
         write_reg(REG_BRIGHT_EN, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 3))
            0: v = 8'd0;
            1: v = 8'(LEVEL_CAP);
            2: v = 8'($urandom_range(0, LEVEL_CAP));
            default: v = 8'($urandom_range(0, 255));
         endcase
         write_reg(REG_BRIGHT_LEVEL, v);
      end
      if ($urandom_range(0, 1))
         write_reg(REG_DUTY_ONE,
                   ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1))
         write_reg(REG_DUTY_ZERO,
                   ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0)
         write_reg(8'($urandom_range(4, 255)), 8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset       = 1;
      csr_valid   = 0;
      csr_index   = '0;
      csr_data    = '0;
      req_valid   = 0;
      req_opcode  = OP_PIXEL;
      req_red     = '0;
      req_green   = '0;
      req_blue    = '0;
      item_typed  = 0;
      item_word   = '0;
      no_idle     = 0;
      error_count = 0;
      cfg_en      = 1;
      cfg_level   = 6'(LEVEL_CAP);
      cfg_one     = 8'd60;
      cfg_zero    = 8'd30;

      // defaults: scaling on at unity, 60/30
      plan.push_back(pix_row(OP_PIXEL, 8'h00, 8'h00, 8'h00, 1, 24'h000000));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 24'hFEFEFE));
      plan.push_back(pix_row(OP_PIXEL, 8'h01, 8'h01, 8'h01, 1, 24'h000000));
      plan.push_back(pix_row(OP_FRAME, 8'h00, 8'h00, 8'h00, 1, 24'h000000));
      plan.push_back(pix_row(OP_PIXEL, 8'h80, 8'h40, 8'hAA, 1, 24'hAA8040));
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'd0));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 24'h000000));
      // above the cap saturates, upper bits are masked off first
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'd46));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'h00, 8'hFF, 1, 24'hFEFE00));
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'hFF));
      plan.push_back(pix_row(OP_PIXEL, 8'h55, 8'hAA, 8'hFF, 1, 24'hFE54AA));
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'h40));
      plan.push_back(pix_row(OP_PIXEL, 8'h55, 8'hAA, 8'hFF, 1, 24'h000000));
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'd30));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'h80, 8'h7F, 0, 24'h0));
      plan.push_back(pix_row(OP_PIXEL, 8'h12, 8'h34, 8'h56, 0, 24'h0));
      // enable write keeps bit 0 only
      plan.push_back(reg_row(REG_BRIGHT_EN, 8'hFE));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 24'hFEFEFE));
      plan.push_back(pix_row(OP_PIXEL, 8'h55, 8'hAA, 8'h01, 1, 24'h0054AA));
      plan.push_back(reg_row(REG_DUTY_ONE, 8'hFF));
      plan.push_back(reg_row(REG_DUTY_ZERO, 8'h00));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'h00, 8'h55, 1, 24'h54FE00));
      plan.push_back(pix_row(OP_FRAME, 8'hFF, 8'hFF, 8'hFF, 1, 24'h000000));
      plan.push_back(reg_row(REG_DUTY_ONE, 8'h00));
      plan.push_back(reg_row(REG_DUTY_ZERO, 8'hFF));
      plan.push_back(pix_row(OP_PIXEL, 8'h00, 8'hFF, 8'hAA, 1, 24'hAA00FE));
      // unknown indexes are dropped
      plan.push_back(reg_row(8'd4, 8'h5A));
      plan.push_back(reg_row(8'hFF, 8'h00));
      plan.push_back(pix_row(OP_PIXEL, 8'hF0, 8'h0F, 8'h3C, 1, 24'h3CF00E));
      plan.push_back(reg_row(REG_BRIGHT_EN, 8'h01));
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'd1));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 24'h0));
      plan.push_back(reg_row(REG_BRIGHT_LEVEL, 8'd44));
      plan.push_back(pix_row(OP_PIXEL, 8'hFF, 8'hFE, 8'h81, 0, 24'h0));
      plan.push_back(reg_row(REG_DUTY_ONE, 8'hAA));
      plan.push_back(reg_row(REG_DUTY_ZERO, 8'h55));
      plan.push_back(pix_row(OP_FRAME, 8'h00, 8'h00, 8'h00, 0, 24'h0));
      plan.push_back(pix_row(OP_PIXEL, 8'hC3, 8'h3C, 8'h99, 0, 24'h0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            wait_drained();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            push_item(plan[i].op, plan[i].red, plan[i].green, plan[i].blue,
                      plan[i].typed, plan[i].word);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         // last phase runs flat out; some earlier ones do too
         no_idle = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 2) == 0);
         shuffle_settings();
         for (int n = 0; n < PHASE_ITEMS; n++)
            push_item(($urandom_range(0, 9) == 0) ? OP_FRAME : OP_PIXEL,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 0, 24'h0);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_slots.size() == 0)
         $display("led_pixel_duty_encoder: match");
      else
         $display("led_pixel_duty_encoder: mismatch");
      $finish;
   end

endmodule
